// ===== hw/rtl/ltb_pkg.sv =====
// Shared types and constants for the luma tint blend block.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package ltb_pkg;

    localparam int PIX_W      = 8;
    localparam int LSUM_W     = 24;   // 255 * 65536 fits in 24 bits
    localparam int LUMA_W     = 17;   // Q0.16, 0..65536
    localparam int STRENGTH_W = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // Luma weights, Q0.16, sum to 65536
    localparam logic [LSUM_W-1:0] LUMA_W_RED   = LSUM_W'(19595);
    localparam logic [LSUM_W-1:0] LUMA_W_GREEN = LSUM_W'(38470);
    localparam logic [LSUM_W-1:0] LUMA_W_BLUE  = LSUM_W'(7471);

    // floor(2^24 / 255); estimate of x / 255 is low by at most one
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 17;
    localparam logic [RECIP_W-1:0] DIV255_RECIP = RECIP_W'(65793);
    localparam logic [LSUM_W:0]    DIV255       = (LSUM_W+1)'(255);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DARK_RED    = 3'd0,
        REG_DARK_GREEN  = 3'd1,
        REG_DARK_BLUE   = 3'd2,
        REG_LIGHT_RED   = 3'd3,
        REG_LIGHT_GREEN = 3'd4,
        REG_LIGHT_BLUE  = 3'd5,
        REG_TINT        = 3'd6
    } ltb_reg_e;

    localparam logic [PIX_W-1:0]      DARK_RESET     = 8'd0;
    localparam logic [PIX_W-1:0]      LIGHT_RESET    = 8'd255;
    localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 9'd256;

    // Pixel plus its luma, leaving the luma pipeline
    typedef struct packed {
        logic [LUMA_W-1:0] luma;
        logic [PIX_W-1:0]  red;
        logic [PIX_W-1:0]  green;
        logic [PIX_W-1:0]  blue;
    } ltb_luma_t;

    // Endpoints of one channel's color ramp
    typedef struct packed {
        logic [PIX_W-1:0] dark;
        logic [PIX_W-1:0] light;
    } ltb_ramp_t;

endpackage : ltb_pkg

`default_nettype wire

// ===== hw/rtl/ltb_ifs.sv =====
// Channel interfaces: input pixel, tinted pixel and register write.
// Depends on ltb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ltb_pix_in_if
    import ltb_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue,
                    output ready);
endinterface : ltb_pix_in_if

interface ltb_pix_out_if
    import ltb_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    output ready);
endinterface : ltb_pix_out_if

interface ltb_cfg_if
    import ltb_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : ltb_cfg_if

`default_nettype wire

// ===== hw/rtl/ltb_luma.sv =====
// Three-stage luma pipeline: weighted sum, reciprocal multiply, correction.
// Depends on ltb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ltb_luma
    import ltb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             pix_valid,
    output logic                  pix_ready,
    input  wire logic [PIX_W-1:0] red,
    input  wire logic [PIX_W-1:0] green,
    input  wire logic [PIX_W-1:0] blue,
    output logic                  luma_valid,
    input  wire logic             luma_ready,
    output ltb_luma_t             luma_item
);

    localparam int PROD_W = LSUM_W + RECIP_W;

    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;
    logic rdy1, rdy2, rdy3;

    logic [LSUM_W-1:0]  lsum;
    logic [LSUM_W-1:0]  lsum1_reg, lsum2_reg;
    logic [PIX_W-1:0]   r1_reg, g1_reg, b1_reg;
    logic [PIX_W-1:0]   r2_reg, g2_reg, b2_reg;
    logic [PROD_W-1:0]  prod;
    logic [LUMA_W-1:0]  q0_reg;
    logic [LSUM_W:0]    q0_x255;
    logic [LSUM_W:0]    rem;
    logic [LUMA_W-1:0]  luma;
    ltb_luma_t          item3_reg;

    // per-stage ready lets bubbles collapse
    assign rdy3 = !v3_reg || luma_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign pix_ready = rdy1;

    assign v1_next = rdy1 ? pix_valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg    : v2_reg;
    assign v3_next = rdy3 ? v2_reg    : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_comb
    begin
        lsum = LUMA_W_RED * LSUM_W'(red) + LUMA_W_GREEN * LSUM_W'(green)
             + LUMA_W_BLUE * LSUM_W'(blue);
        prod = PROD_W'(lsum1_reg) * PROD_W'(DIV255_RECIP);
        // remainder of the estimate; one step up when it reaches 255
        q0_x255 = (LSUM_W+1)'({q0_reg, 8'b0}) - (LSUM_W+1)'(q0_reg);
        rem     = (LSUM_W+1)'(lsum2_reg) - q0_x255;
        luma    = q0_reg + LUMA_W'(rem >= DIV255);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && pix_valid)
        begin
            lsum1_reg <= lsum;
            r1_reg    <= red;
            g1_reg    <= green;
            b1_reg    <= blue;
        end
        if (rdy2 && v1_reg)
        begin
            q0_reg    <= prod[RECIP_SHIFT +: LUMA_W];
            lsum2_reg <= lsum1_reg;
            r2_reg    <= r1_reg;
            g2_reg    <= g1_reg;
            b2_reg    <= b1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            item3_reg.luma  <= luma;
            item3_reg.red   <= r2_reg;
            item3_reg.green <= g2_reg;
            item3_reg.blue  <= b2_reg;
        end
    end

    assign luma_valid = v3_reg;
    assign luma_item  = item3_reg;

endmodule : ltb_luma

`default_nettype wire

// ===== hw/rtl/ltb_lane.sv =====
// One color channel lane: ramp target, difference, blend and clamp.
// Depends on ltb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ltb_lane
    import ltb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  load,
    input  wire logic [PIX_W-1:0]      pix,
    input  wire logic [LUMA_W-1:0]     luma,
    input  wire ltb_ramp_t             ramp,
    input  wire logic [STRENGTH_W-1:0] strength,
    output logic [PIX_W-1:0]           result
);

    localparam int TGT_W  = LUMA_W + PIX_W + 2;        // 27
    localparam int DIFF_W = PIX_W + 16 + 1;            // 25, |diff| < 2^24
    localparam int V_W    = DIFF_W + STRENGTH_W + 2;   // 36

    logic signed [PIX_W:0]    span;
    logic signed [TGT_W-1:0]  scaled;
    logic signed [TGT_W-1:0]  diff_full;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [PIX_W-1:0]         pix_reg;
    logic signed [V_W-1:0]    blend;

    always_comb
    begin
        span      = $signed({1'b0, ramp.light}) - $signed({1'b0, ramp.dark});
        scaled    = TGT_W'(span) * $signed(TGT_W'({1'b0, luma}));
        diff_full = $signed(TGT_W'({ramp.dark, 16'b0})) + scaled
                  - $signed(TGT_W'({pix, 16'b0}));
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            diff_reg <= diff_full[DIFF_W-1:0];
            pix_reg  <= pix;
        end
    end

    always_comb
    begin
        blend = V_W'(diff_reg) * $signed(V_W'({1'b0, strength}))
              + $signed(V_W'({pix_reg, 24'b0}));
        if (blend[V_W-1])
            result = '0;
        else if (blend[V_W-2:32] != '0)
            result = '1;
        else
            result = blend[31:24];
    end

endmodule : ltb_lane

`default_nettype wire

// ===== hw/rtl/ltb_merge.sv =====
// Output stage: gathers the three lane results into the result register.
// Depends on ltb_pkg and ltb_pix_out_if.
`timescale 1ns / 1ps
`default_nettype none

module ltb_merge
    import ltb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             lane_valid,
    output logic                  lane_ready,
    input  wire logic [PIX_W-1:0] red,
    input  wire logic [PIX_W-1:0] green,
    input  wire logic [PIX_W-1:0] blue,
    ltb_pix_out_if.source         tinted
);

    logic             valid_reg;
    logic             valid_next;
    logic [PIX_W-1:0] red_reg, green_reg, blue_reg;

    assign lane_ready = !valid_reg || tinted.ready;
    assign valid_next = lane_ready ? lane_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (lane_ready && lane_valid)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
        end
    end

    assign tinted.valid     = valid_reg;
    assign tinted.out_red   = red_reg;
    assign tinted.out_green = green_reg;
    assign tinted.out_blue  = blue_reg;

endmodule : ltb_merge

`default_nettype wire

// ===== hw/rtl/luma_tint_blend_core.sv =====
// Top level of the luma tint blend block: registers, luma pipeline,
// three channel lanes and the output merge. Depends on ltb_pkg, ltb_ifs,
// ltb_luma, ltb_lane and ltb_merge.
//
// Usage:
//   pixel  - sink of RGB input pixels; a transfer is valid && ready.
//   tinted - source of tinted RGB pixels, one per input pixel, in order.
//   cfg    - register writes (index 0..6: dark red/green/blue, light
//            red/green/blue, tint strength). Always ready; index 7 ignored.
//            Write only while the pipeline is empty.
// Path: a pixel taken on pixel passes three luma stages, one lane stage
//   and the output register before it shows on tinted; the first luma
//   stage loads on the edge that takes the pixel.
// Throughput: one pixel per clock while tinted is ready. The rate is set by
//   the pipeline; every stage takes a new pixel each cycle unless stalled.
// Stalls: each stage has its own ready, so bubbles collapse and the input
//   keeps taking pixels while a result waits until the pipe is full.
// Reset: rst_n clears all valid bits and loads the register defaults
//   (dark = black, light = white, full strength).
`timescale 1ns / 1ps
`default_nettype none

module luma_tint_blend_core
    import ltb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    ltb_pix_in_if.sink    pixel,
    ltb_pix_out_if.source tinted,
    ltb_cfg_if.sink       cfg
);

    // configuration registers
    logic [PIX_W-1:0]      dark_red_reg, dark_green_reg, dark_blue_reg;
    logic [PIX_W-1:0]      light_red_reg, light_green_reg, light_blue_reg;
    logic [STRENGTH_W-1:0] strength_reg;

    ltb_luma_t        luma_item;
    logic             luma_valid;
    logic             luma_ready;

    // lane stage valid
    logic             lane_v_reg;
    logic             lane_v_next;
    logic             lane_stage_ready;
    logic             lane_load;
    logic             merge_ready;

    ltb_ramp_t        ramp_red, ramp_green, ramp_blue;
    logic [PIX_W-1:0] res_red, res_green, res_blue;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_red_reg    <= DARK_RESET;
            dark_green_reg  <= DARK_RESET;
            dark_blue_reg   <= DARK_RESET;
            light_red_reg   <= LIGHT_RESET;
            light_green_reg <= LIGHT_RESET;
            light_blue_reg  <= LIGHT_RESET;
            strength_reg    <= STRENGTH_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DARK_RED:    dark_red_reg    <= cfg.data[PIX_W-1:0];
                REG_DARK_GREEN:  dark_green_reg  <= cfg.data[PIX_W-1:0];
                REG_DARK_BLUE:   dark_blue_reg   <= cfg.data[PIX_W-1:0];
                REG_LIGHT_RED:   light_red_reg   <= cfg.data[PIX_W-1:0];
                REG_LIGHT_GREEN: light_green_reg <= cfg.data[PIX_W-1:0];
                REG_LIGHT_BLUE:  light_blue_reg  <= cfg.data[PIX_W-1:0];
                REG_TINT:        strength_reg    <= cfg.data[STRENGTH_W-1:0];
                default:         ;  // unmapped index, dropped
            endcase
        end
    end

    ltb_luma u_luma (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pixel.valid),
        .pix_ready  (pixel.ready),
        .red        (pixel.in_red),
        .green      (pixel.in_green),
        .blue       (pixel.in_blue),
        .luma_valid (luma_valid),
        .luma_ready (luma_ready),
        .luma_item  (luma_item)
    );

    // lane stage handshake; the lanes hold payload only
    assign lane_stage_ready = !lane_v_reg || merge_ready;
    assign luma_ready       = lane_stage_ready;
    assign lane_load        = lane_stage_ready && luma_valid;
    assign lane_v_next      = lane_stage_ready ? luma_valid : lane_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lane_v_reg <= 1'b0;
        else
            lane_v_reg <= lane_v_next;
    end

    assign ramp_red   = '{dark: dark_red_reg,   light: light_red_reg};
    assign ramp_green = '{dark: dark_green_reg, light: light_green_reg};
    assign ramp_blue  = '{dark: dark_blue_reg,  light: light_blue_reg};

    ltb_lane u_lane_red (
        .clk      (clk),
        .load     (lane_load),
        .pix      (luma_item.red),
        .luma     (luma_item.luma),
        .ramp     (ramp_red),
        .strength (strength_reg),
        .result   (res_red)
    );

    ltb_lane u_lane_green (
        .clk      (clk),
        .load     (lane_load),
        .pix      (luma_item.green),
        .luma     (luma_item.luma),
        .ramp     (ramp_green),
        .strength (strength_reg),
        .result   (res_green)
    );

    ltb_lane u_lane_blue (
        .clk      (clk),
        .load     (lane_load),
        .pix      (luma_item.blue),
        .luma     (luma_item.luma),
        .ramp     (ramp_blue),
        .strength (strength_reg),
        .result   (res_blue)
    );

    ltb_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_valid (lane_v_reg),
        .lane_ready (merge_ready),
        .red        (res_red),
        .green      (res_green),
        .blue       (res_blue),
        .tinted     (tinted)
    );

endmodule : luma_tint_blend_core

`default_nettype wire
